// ===== sv/ucpp_pkg.sv =====
// Package: constants, types and helper functions for the unicycle pose propagation block.
`default_nettype none

package ucpp_pkg;

  localparam int unsigned CORDIC_STAGES = 24;

  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int unsigned CW = 34;

  // Angle constants, Q2.30
  localparam logic signed [35:0] PI_A     = 36'sd3373259426;
  localparam logic signed [35:0] PI3_A    = 36'sd10119778278;
  localparam logic signed [35:0] PI5_A    = 36'sd16866297130;
  localparam logic signed [35:0] TWO_PI_A = 36'sd6746518852;
  localparam logic signed [35:0] FOUR_PI_A = 36'sd13493037704;
  localparam logic signed [35:0] SIX_PI_A = 36'sd20239556556;
  localparam logic signed [35:0] HALF_PI_A = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [52:0] MAX32 = 53'sd2147483647;
  localparam logic signed [52:0] MIN32 = -53'sd2147483648;

  // Sideband carried alongside the CORDIC rotation
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [48:0] hsum;
    logic signed [47:0] travel;
    logic               neg;
  } side_t;

  // arctan(2^-i) in Q2.30
  function automatic logic signed [CW-1:0] atan_f(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    unique case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Saturate to 32 bits; returns {overflow, value}
  function automatic logic [32:0] sat32_f(input logic signed [52:0] v);
    logic [32:0] r;
    if (v > MAX32) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < MIN32) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ucpp_if.sv =====
// Interfaces: request and result channels of the pose propagation block.
`default_nettype none

interface ucpp_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_heading;
  logic        [31:0] start_time;
  logic        [31:0] end_time;
  logic signed [31:0] speed;
  logic signed [31:0] turn_rate;

  modport source (
    output valid, start_x, start_y, start_heading, start_time, end_time, speed, turn_rate,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_heading, start_time, end_time, speed, turn_rate,
    output ready
  );
endinterface

interface ucpp_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_heading;
  logic               overflow;

  modport source (
    output valid, new_x, new_y, new_heading, overflow,
    input  ready
  );
  modport sink (
    input  valid, new_x, new_y, new_heading, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ucpp_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
`default_nettype none

module ucpp_cordic import ucpp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] angle_i,
  input  wire side_t                side_i,
  output logic                      valid_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output side_t                     side_o
);

  logic                 vld_q  [CORDIC_STAGES];
  logic signed [CW-1:0] x_q    [CORDIC_STAGES];
  logic signed [CW-1:0] y_q    [CORDIC_STAGES];
  logic signed [CW-1:0] z_q    [CORDIC_STAGES];
  side_t                side_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic                 vld_in;
    logic signed [CW-1:0] x_in, y_in, z_in;
    side_t                side_in;
    logic signed [CW-1:0] x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign x_in    = GAIN_Q30;
      assign y_in    = '0;
      assign z_in    = angle_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      if (!z_in[CW-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - atan_f(5'(i));
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + atan_f(5'(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign x_o     = x_q[CORDIC_STAGES-1];
  assign y_o     = y_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/unicycle_pose_propagation.sv =====
// Top level: unicycle dead-reckoning pose propagation with a pipelined CORDIC.
// Registers from request transfer to result: stages 1 and 2, the CORDIC stages, stages C+1 to C+4.
// Throughput: one transfer per cycle; the whole pipe advances together whenever the
// output register is empty or its result is taken, so a stall holds every stage.
// Reset: rst_ni (async, active low) clears all valid bits; the datapath is not reset.
`default_nettype none

module unicycle_pose_propagation import ucpp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ucpp_req_if.sink    req_i,
  ucpp_res_if.source  res_o
);

  // Global advance: the output register is free or being drained
  logic en;
  logic out_valid_q;
  assign en        = !out_valid_q || res_o.ready;
  assign req_i.ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: dt, heading to Q2.30, reduction into [-pi, pi]
  // ---------------------------------------------------------------------------
  logic signed [35:0] a_full, a_red;
  logic signed [32:0] dt_d;

  assign a_full = {req_i.start_heading[31], req_i.start_heading, 3'b000};
  assign dt_d   = $signed({1'b0, req_i.end_time}) - $signed({1'b0, req_i.start_time});

  // Reduction: headings above pi land in (-pi, pi], below -pi in [-pi, pi)
  always_comb begin
    priority if (a_full > PI5_A) begin
      a_red = a_full - SIX_PI_A;
    end else if (a_full > PI3_A) begin
      a_red = a_full - FOUR_PI_A;
    end else if (a_full > PI_A) begin
      a_red = a_full - TWO_PI_A;
    end else if (a_full < -PI5_A) begin
      a_red = a_full + SIX_PI_A;
    end else if (a_full < -PI3_A) begin
      a_red = a_full + FOUR_PI_A;
    end else if (a_full < -PI_A) begin
      a_red = a_full + TWO_PI_A;
    end else begin
      a_red = a_full;
    end
  end

  logic               s1_valid_q;
  logic signed [31:0] s1_sx_q, s1_sy_q, s1_sh_q, s1_v_q, s1_w_q;
  logic signed [32:0] s1_dt_q;
  logic signed [35:0] s1_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sx_q <= req_i.start_x;
      s1_sy_q <= req_i.start_y;
      s1_sh_q <= req_i.start_heading;
      s1_v_q  <= req_i.speed;
      s1_w_q  <= req_i.turn_rate;
      s1_dt_q <= dt_d;
      s1_a_q  <= a_red;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fold into [-pi/2, pi/2]; distance and heading change products
  // ---------------------------------------------------------------------------
  logic signed [35:0] a_fold;
  logic               neg_d;
  logic signed [64:0] dtv, dtw;

  always_comb begin
    priority if (s1_a_q > HALF_PI_A) begin
      a_fold = s1_a_q - PI_A;
      neg_d  = 1'b1;
    end else if (s1_a_q < -HALF_PI_A) begin
      a_fold = s1_a_q + PI_A;
      neg_d  = 1'b1;
    end else begin
      a_fold = s1_a_q;
      neg_d  = 1'b0;
    end
  end

  assign dtv = s1_dt_q * s1_v_q;
  assign dtw = s1_dt_q * s1_w_q;

  logic               s2_valid_q;
  logic signed [31:0] s2_sx_q, s2_sy_q, s2_sh_q;
  logic signed [47:0] s2_dist_q, s2_dh_q;
  logic signed [CW-1:0] s2_ang_q;
  logic               s2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
      s2_sh_q   <= s1_sh_q;
      s2_dist_q <= dtv[63:16];   // floor(dt*speed / 2^16)
      s2_dh_q   <= dtw[63:16];   // floor(dt*turn_rate / 2^16)
      s2_ang_q  <= a_fold[CW-1:0];
      s2_neg_q  <= neg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC stages; the heading sum rides along as sideband
  // ---------------------------------------------------------------------------
  side_t              side_in, side_out;
  logic               cr_valid;
  logic signed [CW-1:0] cr_x, cr_y;

  always_comb begin
    side_in.sx     = s2_sx_q;
    side_in.sy     = s2_sy_q;
    side_in.hsum   = 49'(s2_sh_q) + 49'(s2_dh_q);
    side_in.travel = s2_dist_q;
    side_in.neg    = s2_neg_q;
  end

  ucpp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid_q),
    .angle_i (s2_ang_q),
    .side_i  (side_in),
    .valid_o (cr_valid),
    .x_o     (cr_x),
    .y_o     (cr_y),
    .side_o  (side_out)
  );

  // ---------------------------------------------------------------------------
  // Stage C+1: undo the fold (negate cos and sin)
  // ---------------------------------------------------------------------------
  logic                 s3_valid_q;
  logic signed [CW-1:0] s3_c_q, s3_s_q;
  side_t                s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= cr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_c_q    <= side_out.neg ? -cr_x : cr_x;
      s3_s_q    <= side_out.neg ? -cr_y : cr_y;
      s3_side_q <= side_out;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C+2: partial products, distance split as hi*2^24 + lo
  // ---------------------------------------------------------------------------
  logic signed [23:0] d_hi;
  logic signed [24:0] d_lo;
  assign d_hi = s3_side_q.travel[47:24];
  assign d_lo = $signed({1'b0, s3_side_q.travel[23:0]});

  logic               s4_valid_q;
  logic signed [57:0] s4_xh_q, s4_yh_q;
  logic signed [58:0] s4_xl_q, s4_yl_q;
  side_t              s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_xh_q   <= s3_c_q * d_hi;
      s4_xl_q   <= s3_c_q * d_lo;
      s4_yh_q   <= s3_s_q * d_hi;
      s4_yl_q   <= s3_s_q * d_lo;
      s4_side_q <= s3_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C+3: recombine, exact floor of product / 2^30
  // ---------------------------------------------------------------------------
  logic signed [82:0] acc_x, acc_y;
  assign acc_x = (83'(s4_xh_q) <<< 24) + 83'(s4_xl_q);
  assign acc_y = (83'(s4_yh_q) <<< 24) + 83'(s4_yl_q);

  logic               s5_valid_q;
  logic signed [51:0] s5_ox_q, s5_oy_q;
  side_t              s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ox_q   <= acc_x[81:30];
      s5_oy_q   <= acc_y[81:30];
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C+4: final sums and saturation into the output register
  // ---------------------------------------------------------------------------
  logic [32:0] sat_x, sat_y, sat_h;
  assign sat_x = sat32_f(53'(s5_side_q.sx) + 53'(s5_ox_q));
  assign sat_y = sat32_f(53'(s5_side_q.sy) + 53'(s5_oy_q));
  assign sat_h = sat32_f(53'(s5_side_q.hsum));

  logic signed [31:0] new_x_q, new_y_q, new_h_q;
  logic               ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_x_q <= sat_x[31:0];
      new_y_q <= sat_y[31:0];
      new_h_q <= sat_h[31:0];
      ovf_q   <= sat_x[32] | sat_y[32] | sat_h[32];
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.new_x       = new_x_q;
  assign res_o.new_y       = new_y_q;
  assign res_o.new_heading = new_h_q;
  assign res_o.overflow    = ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An empty output register must never block the request side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("request blocked with empty output register");

  // A transfer always enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted request lost at first stage");

  // A flagged result carries at least one clamped value
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |->
      (new_x_q == 32'sh7FFF_FFFF || new_x_q == -32'sh8000_0000 ||
       new_y_q == 32'sh7FFF_FFFF || new_y_q == -32'sh8000_0000 ||
       new_h_q == 32'sh7FFF_FFFF || new_h_q == -32'sh8000_0000))
    else $error("overflow flag without a saturated output");

endmodule

`default_nettype wire
